[sv/bcmio_pkg.sv]
// ---------------------------------------------------------------------------
// bcmio_pkg
// Shared types, codes and defaults for the bus cycle memory/IO controller.
// ---------------------------------------------------------------------------
package bcmio_pkg;

  // Default sizes
  localparam int RAM_PAGES_DEF = 48;
  localparam int MEM_DEPTH_DEF = 16384;

  // Transaction kinds
  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_INTACK = 2'd1;
  localparam logic [1:0] KIND_LOAD   = 2'd2;
  localparam logic [1:0] KIND_START  = 2'd3;

  // Pointer vectors in low memory
  localparam logic [7:0] INJECT_VECTOR = 8'h41;
  localparam logic [7:0] LOG_VECTOR    = 8'h42;

  // I/O codes (whole high byte)
  localparam logic [7:0] IO_STATUS  = 8'h41;
  localparam logic [7:0] IO_RX      = 8'h43;
  localparam logic [7:0] IO_INT_ON  = 8'h51;
  localparam logic [7:0] IO_INT_OFF = 8'h53;
  localparam logic [7:0] IO_TX      = 8'h61;

  // Cycle type bits of the high byte
  localparam int TYPE_IO_BIT = 6;
  localparam int TYPE_WR_BIT = 7;

  // Input transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] low_byte;
    logic [7:0] high_byte;
    logic [7:0] write_data;
    logic [7:0] uart_status;
    logic [7:0] uart_rx_byte;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] read_data;
    logic       drive_bus;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_pop;
    logic       int_line;
  } out_item_t;

  // Command from controller to datapath: one step per cycle
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_LOG_LO,
    STEP_READ,
    STEP_LOG_HI,
    STEP_WRITE,
    STEP_VEC_LOG,
    STEP_VEC_INJ,
    STEP_FIN
  } step_t;

  // Decoded transaction status from datapath to controller
  typedef struct packed {
    logic do_read;
    logic do_log_hi;
    logic do_write;
    logic do_reload;
  } dp_status_t;

endpackage

[sv/bcmio_ram.sv]
// ---------------------------------------------------------------------------
// bcmio_ram
// Generic RAM, one write port and one read port, registered read data.
// ---------------------------------------------------------------------------
module bcmio_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/bcmio_ctrl.sv]
// ---------------------------------------------------------------------------
// bcmio_ctrl
// Sequencer: walks a transaction through its memory steps, one per cycle.
// ---------------------------------------------------------------------------
module bcmio_ctrl
  import bcmio_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output logic       latch,
  output step_t      step
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOG_LO,
    S_READ,
    S_LOG_HI,
    S_WRITE,
    S_VEC_LOG,
    S_VEC_INJ,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  assign latch = start && !busy_r;
  assign busy  = busy_r;

  // Next state: skip steps the transaction does not need
  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    case (state_r)
      S_IDLE: begin
        if (latch) begin
          state_nxt = S_LOG_LO;
          busy_nxt  = 1'b1;
        end
      end
      S_LOG_LO: begin
        if (status.do_read)        state_nxt = S_READ;
        else if (status.do_log_hi) state_nxt = S_LOG_HI;
        else if (status.do_write)  state_nxt = S_WRITE;
        else if (status.do_reload) state_nxt = S_VEC_LOG;
        else                       state_nxt = S_FIN;
      end
      S_READ: begin
        if (status.do_log_hi) state_nxt = S_LOG_HI;
        else                  state_nxt = S_FIN;
      end
      S_LOG_HI: begin
        if (status.do_write)       state_nxt = S_WRITE;
        else if (status.do_reload) state_nxt = S_VEC_LOG;
        else                       state_nxt = S_FIN;
      end
      S_WRITE:   state_nxt = S_FIN;
      S_VEC_LOG: state_nxt = S_VEC_INJ;
      S_VEC_INJ: state_nxt = S_FIN;
      S_FIN: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  // State and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // Command to datapath
  always_comb begin
    case (state_r)
      S_LOG_LO:  step = STEP_LOG_LO;
      S_READ:    step = STEP_READ;
      S_LOG_HI:  step = STEP_LOG_HI;
      S_WRITE:   step = STEP_WRITE;
      S_VEC_LOG: step = STEP_VEC_LOG;
      S_VEC_INJ: step = STEP_VEC_INJ;
      S_FIN:     step = STEP_FIN;
      default:   step = STEP_NONE;
    endcase
  end

endmodule

[sv/bcmio_dp.sv]
// ---------------------------------------------------------------------------
// bcmio_dp
// Datapath: transaction register, pointers, interrupt flag, memory port
// steering and result register.
// ---------------------------------------------------------------------------
module bcmio_dp
  import bcmio_pkg::*;
#(
  parameter int RAM_PAGES = RAM_PAGES_DEF,
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       latch,
  input  step_t      step,
  input  in_item_t   in_item,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [14:0] ADDR_LIMIT = 15'(MEM_DEPTH);
  localparam logic [6:0]  PAGE_LIMIT = 7'(RAM_PAGES);

  in_item_t  item_r;
  logic [7:0] lp_r, ip_r;
  logic       irq_r;
  logic       oob_r;
  logic       out_valid_r;
  out_item_t  out_r;

  // RAM port signals
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, q;

  // Decode of the held transaction
  logic [7:0]  hi;
  logic [13:0] addr;
  logic        in_range, page_ok;
  logic        intr, norm, cyc, mem_rd, is_io, is_wr;
  logic        reload, log_inc;

  assign hi       = item_r.high_byte;
  assign addr     = {hi[5:0], item_r.low_byte};
  assign in_range = {1'b0, addr} < ADDR_LIMIT;
  assign page_ok  = {1'b0, hi[5:0]} < PAGE_LIMIT;
  assign intr     = item_r.kind == KIND_INTACK;
  assign norm     = item_r.kind == KIND_NORMAL;
  assign cyc      = intr || norm;
  assign mem_rd   = cyc && !hi[TYPE_IO_BIT];
  assign is_io    = cyc && hi[TYPE_IO_BIT] && !hi[TYPE_WR_BIT];
  assign is_wr    = cyc && hi[TYPE_IO_BIT] && hi[TYPE_WR_BIT];
  assign reload   = (item_r.kind == KIND_START) || (norm && is_io && hi == IO_INT_ON) ||
                    (intr && is_io && hi == IO_INT_OFF);
  assign log_inc  = !(is_io && hi == IO_INT_OFF);

  assign status.do_read   = mem_rd;
  assign status.do_log_hi = intr;
  assign status.do_write  = (item_r.kind == KIND_LOAD) || (is_wr && page_ok);
  assign status.do_reload = reload;

  // Memory port steering per step
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = AW'(lp_r);
    raddr = AW'(addr[AW-1:0]);
    wdata = hi;
    case (step)
      STEP_LOG_LO: begin
        we    = intr;
        wdata = item_r.low_byte;
      end
      STEP_READ: begin
        re = intr || in_range;
        if (intr) raddr = AW'(ip_r);
      end
      STEP_LOG_HI: we = 1'b1;
      STEP_WRITE: begin
        we    = in_range;
        waddr = addr[AW-1:0];
        wdata = item_r.write_data;
      end
      STEP_VEC_LOG: begin
        re    = 1'b1;
        raddr = AW'(LOG_VECTOR);
      end
      STEP_VEC_INJ: begin
        re    = 1'b1;
        raddr = AW'(INJECT_VECTOR);
      end
      default: ;
    endcase
  end

  bcmio_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (q)
  );

  // Transaction register
  always_ff @(posedge clk) begin
    if (latch) item_r <= in_item;
  end

  // Out-of-range flag for a plain memory read
  always_ff @(posedge clk) begin
    if (step == STEP_READ) oob_r <= !intr && !in_range;
  end

  // Result value, built in the final step
  out_item_t res;
  always_comb begin
    res           = '0;
    res.int_line  = irq_r;
    if (mem_rd) begin
      res.drive_bus = 1'b1;
      res.read_data = oob_r ? 8'h00 : q;
    end else if (is_io) begin
      case (hi)
        IO_STATUS: begin
          res.drive_bus = 1'b1;
          res.read_data = item_r.uart_status;
        end
        IO_RX: begin
          res.drive_bus = 1'b1;
          res.read_data = item_r.uart_rx_byte;
          res.rx_pop    = 1'b1;
        end
        IO_TX: begin
          res.tx_valid = 1'b1;
          res.tx_byte  = item_r.low_byte;
        end
        IO_INT_ON:  res.int_line = 1'b1;
        IO_INT_OFF: res.int_line = 1'b0;
        default: ;
      endcase
    end else if (item_r.kind == KIND_START) begin
      res.int_line = 1'b1;
    end
  end

  // Pointers, interrupt request and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r        <= 8'h00;
      ip_r        <= 8'h00;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= step == STEP_FIN;
      case (step)
        STEP_LOG_LO: if (intr) lp_r <= lp_r + 8'd1;
        STEP_READ:   if (intr) ip_r <= ip_r + 8'd1;
        STEP_LOG_HI: if (log_inc) lp_r <= lp_r + 8'd1;
        STEP_VEC_INJ: lp_r <= q;
        STEP_FIN: begin
          if (reload) ip_r <= q;
          irq_r <= res.int_line;
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (step == STEP_FIN) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[sv/bus_cycle_memory_io_controller.sv]
// ---------------------------------------------------------------------------
// bus_cycle_memory_io_controller
// Serves one 8-bit CPU bus cycle, image-load write or start command per
// transaction against a byte store with UART and interrupt I/O codes.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Its result
// shows on out_item for one cycle with out_valid; there is no back-pressure,
// so the receiver must take it then. All work goes through one memory with
// one access per cycle. A transaction holds busy for a first step (the
// low-byte log in an interrupt cycle, otherwise decode only), one step per
// memory access and a final step. A plain I/O code other than interrupt-on
// or a write to a read-only page adds no step; a memory read, a RAM write or
// an image load adds its access; an interrupt acknowledge adds the high-byte
// log and any read or RAM write; a start or a plain interrupt-on code adds
// the two pointer reloads, and an interrupt acknowledge with the
// interrupt-off code adds both the high-byte log and the reloads. The result
// appears in the first cycle with busy low, and a new start may be taken in
// that same cycle. The store is not cleared at reset; load it before reading.
module bus_cycle_memory_io_controller
  import bcmio_pkg::*;
#(
  parameter int RAM_PAGES = RAM_PAGES_DEF,
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic       latch;
  step_t      step;
  dp_status_t status;

  bcmio_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .latch  (latch),
    .step   (step)
  );

  bcmio_dp #(
    .RAM_PAGES (RAM_PAGES),
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .latch     (latch),
    .step      (step),
    .in_item   (in_item),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_undriven_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.drive_bus |-> out_item.read_data == 8'h00)
    else $error("read data nonzero while bus not driven");

  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.tx_valid |-> out_item.tx_byte == 8'h00)
    else $error("tx byte nonzero without tx valid");

endmodule

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for bus_cycle_memory_io_controller. A short directed
// table, an image load of the low page and random bus cycles, about a
// thousand transactions in all, are sent through the start/busy port. Each
// result is checked field by field against its typed row or else a local
// model of the byte store, the interrupt line and the inject and log pointers.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcmio_pkg::*;

  localparam logic [7:0] IO_CODE_SET [5] = '{IO_STATUS, IO_RX, IO_INT_ON, IO_INT_OFF, IO_TX};

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Directed table row; want is used only where typed is set
  typedef struct {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } bus_row_t;

  bus_row_t  directed_rows[$];
  out_item_t bus_results_due[$];

  // Model state
  logic [7:0] store_img [MEM_DEPTH_DEF];
  bit         store_set [MEM_DEPTH_DEF];
  logic [7:0] inject_ptr = 8'h00;
  logic [7:0] log_ptr    = 8'h00;
  logic       irq_level  = 1'b0;

  // Typed expectation that travels with the transaction on the port
  logic      typed_on;
  out_item_t typed_result;

  logic      quiet_stretch;
  int        items_sent;
  int        results_seen;
  int        mismatches;
  int        random_base;
  out_item_t want_now;
  out_item_t model_now;
  in_item_t  item;
  int        burst;

  bus_cycle_memory_io_controller u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  // ---- model of the controller ----

  function automatic logic [7:0] fetch_byte(logic [13:0] a);
    return (int'(a) < MEM_DEPTH_DEF) ? store_img[a] : 8'h00;
  endfunction

  function automatic void store_byte(logic [13:0] a, logic [7:0] v);
    if (int'(a) < MEM_DEPTH_DEF) begin
      store_img[a] = v;
      store_set[a] = 1'b1;
    end
  endfunction

  function automatic void log_bus_byte(logic [7:0] v);
    store_byte({6'b0, log_ptr}, v);
    log_ptr = log_ptr + 8'd1;
  endfunction

  function automatic void reload_ptrs();
    log_ptr    = fetch_byte({6'b0, LOG_VECTOR});
    inject_ptr = fetch_byte({6'b0, INJECT_VECTOR});
  endfunction

  function automatic out_item_t serve_bus_cycle(in_item_t it);
    out_item_t   r;
    logic [13:0] addr;
    logic        intack;
    r      = '0;
    addr   = {it.high_byte[5:0], it.low_byte};
    intack = (it.kind == KIND_INTACK);
    if (it.kind == KIND_LOAD) begin
      store_byte(addr, it.write_data);
    end else if (it.kind == KIND_START) begin
      reload_ptrs();
      irq_level = 1'b1;
    end else begin
      if (intack) log_bus_byte(it.low_byte);
      if (!it.high_byte[TYPE_IO_BIT]) begin
        // memory read; interrupt cycles take injected bytes instead
        r.drive_bus = 1'b1;
        if (intack) begin
          r.read_data = fetch_byte({6'b0, inject_ptr});
          inject_ptr  = inject_ptr + 8'd1;
          log_bus_byte(it.high_byte);
        end else begin
          r.read_data = fetch_byte(addr);
        end
      end else if (!it.high_byte[TYPE_WR_BIT]) begin
        case (it.high_byte)
          IO_STATUS: begin
            r.read_data = it.uart_status;
            r.drive_bus = 1'b1;
            if (intack) log_bus_byte(it.high_byte);
          end
          IO_RX: begin
            r.read_data = it.uart_rx_byte;
            r.drive_bus = 1'b1;
            r.rx_pop    = 1'b1;
            if (intack) log_bus_byte(it.high_byte);
          end
          IO_INT_ON: begin
            irq_level = 1'b1;
            if (intack) log_bus_byte(it.high_byte);
            else reload_ptrs();
          end
          IO_INT_OFF: begin
            // leaving the interrupt: last log byte without advance, then reload
            irq_level = 1'b0;
            if (intack) begin
              store_byte({6'b0, log_ptr}, it.high_byte);
              reload_ptrs();
            end
          end
          IO_TX: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = it.low_byte;
            if (intack) log_bus_byte(it.high_byte);
          end
          default: begin
            if (intack) log_bus_byte(it.high_byte);
          end
        endcase
      end else begin
        if (intack) log_bus_byte(it.high_byte);
        if (int'(it.high_byte[5:0]) < RAM_PAGES_DEF) store_byte(addr, it.write_data);
      end
    end
    r.int_line = irq_level;
    return r;
  endfunction

  // ---- stimulus helpers ----

  function automatic void add_row(logic [1:0] kind, logic [7:0] lo, logic [7:0] hi,
                                  logic [7:0] wd, logic [7:0] st, logic [7:0] rx,
                                  int typed, logic [7:0] rd, int drv, int txv,
                                  logic [7:0] txb, int pop, int irq);
    bus_row_t row;
    row.stim  = '{kind, lo, hi, wd, st, rx};
    row.typed = (typed != 0);
    row.want  = '{rd, drv != 0, txv != 0, txb, pop != 0, irq != 0};
    directed_rows.push_back(row);
  endfunction

  // Random bus cycle of the given kind; bus cycles lean toward real codes
  // and writable pages
  function automatic in_item_t random_bus_cycle(logic [1:0] kind);
    in_item_t it;
    it.kind         = kind;
    it.low_byte     = 8'($urandom_range(0, 255));
    it.high_byte    = 8'($urandom_range(0, 255));
    it.write_data   = 8'($urandom_range(0, 255));
    it.uart_status  = 8'($urandom_range(0, 255));
    it.uart_rx_byte = 8'($urandom_range(0, 255));
    if (kind == KIND_NORMAL || kind == KIND_INTACK) begin
      case ($urandom_range(0, 2))
        0: begin
          it.high_byte[TYPE_IO_BIT] = 1'b0;
          // plain reads stay on written bytes; page 0 is loaded up front
          if (kind == KIND_NORMAL && !store_set[{it.high_byte[5:0], it.low_byte}])
            it.high_byte[5:0] = 6'd0;
        end
        1: begin
          it.high_byte[7:6] = 2'b01;
          if ($urandom_range(0, 9) < 7) it.high_byte = IO_CODE_SET[$urandom_range(0, 4)];
        end
        default: begin
          it.high_byte[7:6] = 2'b11;
          if ($urandom_range(0, 9) < 7)
            it.high_byte[5:0] = 6'($urandom_range(0, RAM_PAGES_DEF - 1));
        end
      endcase
    end
    return it;
  endfunction

  // Drive one transaction and hold it until the block takes it
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    int gap;
    gap = (!quiet_stretch && $urandom_range(0, 99) < 9) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_item      <= it;
    typed_on     <= typed;
    typed_result <= want;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: result %0d: %s", $time, results_seen, what);
  endtask

  // ---- result checking ----
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        model_now = serve_bus_cycle(in_item);
        bus_results_due.push_back(typed_on ? typed_result : model_now);
      end
      if (out_valid) begin
        if (bus_results_due.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want_now = bus_results_due.pop_front();
          if (out_item.read_data !== want_now.read_data)
            report_mismatch($sformatf("read_data %h, want %h", out_item.read_data,
                                      want_now.read_data));
          if (out_item.drive_bus !== want_now.drive_bus)
            report_mismatch($sformatf("drive_bus %b, want %b", out_item.drive_bus,
                                      want_now.drive_bus));
          if (out_item.tx_valid !== want_now.tx_valid)
            report_mismatch($sformatf("tx_valid %b, want %b", out_item.tx_valid,
                                      want_now.tx_valid));
          if (out_item.tx_byte !== want_now.tx_byte)
            report_mismatch($sformatf("tx_byte %h, want %h", out_item.tx_byte,
                                      want_now.tx_byte));
          if (out_item.rx_pop !== want_now.rx_pop)
            report_mismatch($sformatf("rx_pop %b, want %b", out_item.rx_pop, want_now.rx_pop));
          if (out_item.int_line !== want_now.int_line)
            report_mismatch($sformatf("int_line %b, want %b", out_item.int_line,
                                      want_now.int_line));
        end
        results_seen++;
      end
    end
  end

  // ---- main sequence ----
  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_item       = '0;
    typed_on      = 1'b0;
    typed_result  = '0;
    quiet_stretch = 1'b0;
    items_sent    = 0;
    results_seen  = 0;
    mismatches    = 0;

    // kind        lo     hi          wd     st     rx    typed rd   drv  txv  txb  pop  irq
    add_row(KIND_LOAD,   8'h41, 8'h00,      8'h80, 8'h00, 8'h00, 1, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_LOAD,   8'h42, 8'h00,      8'hC0, 8'h00, 8'h00, 1, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_LOAD,   8'h80, 8'h00,      8'hE7, 8'h00, 8'h00, 1, 8'h00, 0, 0, 8'h00, 0, 0);
    // top of store; type bits are don't-care on a load
    add_row(KIND_LOAD,   8'hFF, 8'hFF,      8'hFF, 8'hFF, 8'hFF, 1, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_LOAD,   8'h00, 8'hC0,      8'h00, 8'h00, 8'h00, 1, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_NORMAL, 8'hFF, 8'h3F,      8'h00, 8'h00, 8'h00, 1, 8'hFF, 1, 0, 8'h00, 0, 0);
    // bit 7 set with bit 6 clear is still a read
    add_row(KIND_NORMAL, 8'h00, 8'h80,      8'hFF, 8'h00, 8'h00, 1, 8'h00, 1, 0, 8'h00, 0, 0);
    add_row(KIND_NORMAL, 8'h00, IO_STATUS,  8'h00, 8'hA5, 8'h00, 1, 8'hA5, 1, 0, 8'h00, 0, 0);
    add_row(KIND_NORMAL, 8'h00, IO_RX,      8'h00, 8'h00, 8'h5A, 1, 8'h5A, 1, 0, 8'h00, 1, 0);
    add_row(KIND_NORMAL, 8'hFF, IO_TX,      8'h00, 8'h00, 8'h00, 1, 8'h00, 0, 1, 8'hFF, 0, 0);
    // unused I/O code
    add_row(KIND_NORMAL, 8'h00, 8'h7F,      8'h00, 8'h00, 8'h00, 1, 8'h00, 0, 0, 8'h00, 0, 0);
    // last writable page, then read back
    add_row(KIND_NORMAL, 8'h00, 8'hEF,      8'h3C, 8'h00, 8'h00, 1, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_NORMAL, 8'h00, 8'h2F,      8'h00, 8'h00, 8'h00, 1, 8'h3C, 1, 0, 8'h00, 0, 0);
    // write to read-only page is dropped
    add_row(KIND_NORMAL, 8'hFF, 8'hFF,      8'h00, 8'h00, 8'h00, 1, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_NORMAL, 8'hFF, 8'h3F,      8'h00, 8'h00, 8'h00, 1, 8'hFF, 1, 0, 8'h00, 0, 0);
    add_row(KIND_START,  8'h00, 8'h00,      8'h00, 8'h00, 8'h00, 1, 8'h00, 0, 0, 8'h00, 0, 1);
    // interrupt acknowledge sequence, checked against the model
    add_row(KIND_INTACK, 8'h12, 8'h00,      8'h00, 8'h00, 8'h00, 0, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_INTACK, 8'h34, IO_TX,      8'h00, 8'h00, 8'h00, 0, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_INTACK, 8'h56, IO_INT_ON,  8'h00, 8'h00, 8'h00, 0, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_INTACK, 8'h90, 8'hC0,      8'h11, 8'h00, 8'h00, 0, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_INTACK, 8'h00, IO_STATUS,  8'h00, 8'h3C, 8'h00, 0, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_INTACK, 8'h78, IO_INT_OFF, 8'h00, 8'h00, 8'h00, 0, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_NORMAL, 8'h00, IO_INT_ON,  8'h00, 8'h00, 8'h00, 1, 8'h00, 0, 0, 8'h00, 0, 1);
    add_row(KIND_NORMAL, 8'h00, IO_INT_OFF, 8'h00, 8'h00, 8'h00, 1, 8'h00, 0, 0, 8'h00, 0, 0);
    add_row(KIND_NORMAL, 8'h90, 8'h00,      8'h00, 8'h00, 8'h00, 0, 8'h00, 0, 0, 8'h00, 0, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    // Load page 0, which holds the vectors and everything the pointers reach
    for (int a = 0; a < 256; a++) begin
      item           = random_bus_cycle(KIND_LOAD);
      item.low_byte  = a[7:0];
      item.high_byte = {item.high_byte[7:6], 6'd0};
      send_item(item, 1'b0, '0);
    end

    // Random part: mostly interrupt sequences with random content, plus noise
    random_base = items_sent;
    while (items_sent - random_base < 750) begin
      quiet_stretch = (items_sent - random_base >= 300) && (items_sent - random_base < 450);
      if ($urandom_range(0, 99) < 45) begin
        item = random_bus_cycle(KIND_NORMAL);
        if ($urandom_range(0, 1) == 0) item.kind = KIND_START;
        else item.high_byte = IO_INT_ON;
        send_item(item, 1'b0, '0);
        burst = $urandom_range(1, 8);
        repeat (burst) send_item(random_bus_cycle(KIND_INTACK), 1'b0, '0);
        // an occasional sequence is left open
        if ($urandom_range(0, 9) != 0) begin
          item           = random_bus_cycle(KIND_INTACK);
          item.high_byte = IO_INT_OFF;
          send_item(item, 1'b0, '0);
        end
      end else begin
        send_item(random_bus_cycle(2'($urandom_range(0, 3))), 1'b0, '0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
